// ----- hdl/hruhe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hruhe_pkg;

  typedef logic [7:0] byte_t;

  // Line delimiters.
  localparam byte_t CH_CR = 8'h0D;
  localparam byte_t CH_LF = 8'h0A;

  // Lowercase match patterns; input bytes are folded before comparison.
  localparam byte_t PAT_GET  [4] = '{8'h67, 8'h65, 8'h74, 8'h20};
  localparam byte_t PAT_POST [5] = '{8'h70, 8'h6F, 8'h73, 8'h74, 8'h20};
  localparam byte_t PAT_HOST [6] = '{8'h68, 8'h6F, 8'h73, 8'h74, 8'h3A, 8'h20};
  localparam byte_t PAT_TAIL [6] = '{8'h20, 8'h68, 8'h74, 8'h74, 8'h70, 8'h2F};

  // Method prefix lengths, shortest examined lines and lengths to exceed.
  localparam logic [2:0] PLEN_GET    = 3'd4;
  localparam logic [2:0] PLEN_POST   = 3'd5;
  localparam logic [2:0] MINLEN_GET  = 3'd6;
  localparam logic [2:0] MINLEN_POST = 3'd7;
  localparam logic [3:0] WANT_GET    = 4'd14;
  localparam logic [3:0] WANT_POST   = 4'd15;
  localparam logic [3:0] TAIL_LEN    = 4'd9;
  localparam logic [2:0] HOST_PLEN   = 3'd6;

  // Method selection codes.
  localparam logic MODE_GET  = 1'b0;
  localparam logic MODE_POST = 1'b1;

  // ASCII uppercase to lowercase.
  function automatic byte_t fold(input byte_t c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hruhe_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Payload byte channel.
interface hruhe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// Per-packet result channel.
interface hruhe_out_if;
  logic        valid;
  logic        ready;
  logic        request_found;
  logic [10:0] uri_offset;
  logic [10:0] uri_length;
  logic        host_found;
  logic [10:0] host_offset;
  logic [10:0] host_length;
  logic        truncated;

  modport source (output valid, request_found, uri_offset, uri_length, host_found,
                  host_offset, host_length, truncated, input ready);
  modport sink (input valid, request_found, uri_offset, uri_length, host_found,
                host_offset, host_length, truncated, output ready);
endinterface

// Method mode register write channel.
interface hruhe_cfg_if;
  logic valid;
  logic ready;
  logic method_mode;

  modport source (output valid, method_mode, input ready);
  modport sink (input valid, method_mode, output ready);
endinterface

`default_nettype wire

// ----- hdl/http_request_uri_host_extract.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                                        | Beat
// ---------+-----+------------------------------------------------+------------------
// in_bus   | in  | data_byte[7:0], last_byte                      | one packet byte
// out_bus  | out | request_found, uri_offset/length, host_found,  | one per packet
//          |     | host_offset/length, truncated                  |
// cfg_bus  | in  | method_mode                                    | register write
//
// One byte per cycle while no last byte waits: a beat lands in the input
// register and updates the line state in the next cycle. A packet's result
// is registered as its last byte leaves the input register; a last byte waits
// there only while the result register still holds an untaken result. rst_n
// is synchronous; after reset the mode is GET and the packet state is clear.
module http_request_uri_host_extract
  import hruhe_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire          clk,
  input  wire          rst_n,
  hruhe_in_if.sink     in_bus,
  hruhe_out_if.source  out_bus,
  hruhe_cfg_if.sink    cfg_bus
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int LW    = (POS_W > 11) ? POS_W : 11;

  // Configuration.
  logic mode_r;

  // Input register.
  logic  s1_vld_r;
  byte_t s1_byte_r;
  logic  s1_last_r;

  // Packet state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] lcnt_r, lcnt_nxt;
  logic [10:0]      lbeg_r, lbeg_nxt;
  logic [1:0]       cand_r, cand_nxt;
  byte_t            tail_r [10];
  byte_t            tail_nxt [10];
  logic             uf_r, uf_nxt;
  logic             hf_r, hf_nxt;
  logic             fin_r, fin_nxt;
  logic             ovf_r, ovf_nxt;
  logic [10:0]      uri_off_r, uri_off_nxt;
  logic [10:0]      uri_len_r, uri_len_nxt;
  logic [10:0]      host_off_r, host_off_nxt;
  logic [10:0]      host_len_r, host_len_nxt;

  // Result register.
  logic        out_vld_r;
  logic        out_req_r;
  logic [10:0] out_uri_off_r;
  logic [10:0] out_uri_len_r;
  logic        out_host_r;
  logic [10:0] out_host_off_r;
  logic [10:0] out_host_len_r;
  logic        out_trunc_r;

  logic adv;
  logic out_free;
  logic pos_full;
  logic take;
  byte_t fbyte;

  // Handshakes: a byte moves on unless it is a last byte facing a full result.
  assign out_free      = !out_vld_r || out_bus.ready;
  assign adv           = s1_vld_r && (!s1_last_r || out_free);
  assign in_bus.ready  = !s1_vld_r || adv;
  assign cfg_bus.ready = 1'b1;

  assign pos_full = (pos_r == POS_W'(MAX_PACKET_BYTES));
  assign take     = !pos_full && !fin_r;
  assign fbyte    = fold(s1_byte_r);

  // Line end evaluation.
  logic             line_cr;
  logic [POS_W-1:0] line_bytes;
  logic [LW-1:0]    len_w;
  logic [LW-1:0]    pos_w;
  logic [2:0]       plen;
  logic             len_ok;
  logic             want_ok;
  logic             tail_ok;
  logic             uri_ok;
  logic [10:0]      uri_off_calc, uri_len_calc, host_off_calc, host_len_calc;

  assign line_cr    = (lcnt_r != '0) && (tail_r[0] == CH_CR);
  assign line_bytes = lcnt_r - POS_W'(line_cr);
  assign len_w      = LW'(line_bytes);
  assign pos_w      = LW'(pos_r);
  assign plen       = (mode_r == MODE_POST) ? PLEN_POST : PLEN_GET;
  assign len_ok     = (mode_r == MODE_POST) ? (line_bytes >= POS_W'(MINLEN_POST))
                                            : (line_bytes >= POS_W'(MINLEN_GET));
  assign want_ok    = (mode_r == MODE_POST) ? (line_bytes > POS_W'(WANT_POST))
                                            : (line_bytes > POS_W'(WANT_GET));

  // " HTTP/" must sit nine bytes before the line end, past a dropped CR.
  always_comb begin
    tail_ok = 1'b1;
    for (int j = 0; j < 6; j++) begin
      if (fold(line_cr ? tail_r[9-j] : tail_r[8-j]) != PAT_TAIL[j]) begin
        tail_ok = 1'b0;
      end
    end
  end

  assign uri_ok        = cand_r[0] && want_ok && tail_ok;
  assign uri_off_calc  = lbeg_r + 11'(plen);
  assign uri_len_calc  = len_w[10:0] - 11'(plen) - 11'(TAIL_LEN);
  assign host_off_calc = lbeg_r + 11'(HOST_PLEN);
  assign host_len_calc = len_w[10:0] - 11'(HOST_PLEN);

  // Per-byte state update.
  always_comb begin
    pos_nxt      = pos_r;
    lcnt_nxt     = lcnt_r;
    lbeg_nxt     = lbeg_r;
    cand_nxt     = cand_r;
    tail_nxt     = tail_r;
    uf_nxt       = uf_r;
    hf_nxt       = hf_r;
    ovf_nxt      = ovf_r | pos_full;
    uri_off_nxt  = uri_off_r;
    uri_len_nxt  = uri_len_r;
    host_off_nxt = host_off_r;
    host_len_nxt = host_len_r;
    if (!pos_full) begin
      pos_nxt = pos_r + 1'b1;
    end
    if (take) begin
      if (s1_byte_r == CH_LF) begin
        if (len_ok) begin
          if (mode_r == MODE_GET) begin
            if (!uf_r && cand_r[0]) begin
              if (uri_ok) begin
                uri_off_nxt = uri_off_calc;
                uri_len_nxt = uri_len_calc;
                uf_nxt      = 1'b1;
              end
            end else if (!hf_r && cand_r[1]) begin
              host_off_nxt = host_off_calc;
              host_len_nxt = host_len_calc;
              hf_nxt       = 1'b1;
            end
          end else begin
            if (uri_ok) begin
              uri_off_nxt = uri_off_calc;
              uri_len_nxt = uri_len_calc;
              uf_nxt      = 1'b1;
            end
            if (cand_r[1]) begin
              host_off_nxt = host_off_calc;
              host_len_nxt = host_len_calc;
              hf_nxt       = 1'b1;
            end
          end
        end
        lbeg_nxt = pos_w[10:0] + 11'd1;
        lcnt_nxt = '0;
        cand_nxt = 2'b11;
      end else begin
        // Prefix candidates die on the first mismatching byte.
        if (mode_r == MODE_POST) begin
          if (lcnt_r < POS_W'(5) && fbyte != PAT_POST[lcnt_r[2:0]]) begin
            cand_nxt[0] = 1'b0;
          end
        end else begin
          if (lcnt_r < POS_W'(4) && fbyte != PAT_GET[lcnt_r[1:0]]) begin
            cand_nxt[0] = 1'b0;
          end
        end
        if (lcnt_r < POS_W'(6) && fbyte != PAT_HOST[lcnt_r[2:0]]) begin
          cand_nxt[1] = 1'b0;
        end
        for (int i = 9; i > 0; i--) begin
          tail_nxt[i] = tail_r[i-1];
        end
        tail_nxt[0] = s1_byte_r;
        lcnt_nxt    = lcnt_r + 1'b1;
      end
    end
    fin_nxt = fin_r | (uf_nxt & hf_nxt);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      mode_r <= cfg_bus.method_mode;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.data_byte;
      s1_last_r <= in_bus.last_byte;
    end
  end

  // Packet state; a last byte clears it for the next packet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      lcnt_r <= '0;
      lbeg_r <= '0;
      cand_r <= 2'b11;
      uf_r   <= 1'b0;
      hf_r   <= 1'b0;
      fin_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (adv) begin
      if (s1_last_r) begin
        pos_r  <= '0;
        lcnt_r <= '0;
        lbeg_r <= '0;
        cand_r <= 2'b11;
        uf_r   <= 1'b0;
        hf_r   <= 1'b0;
        fin_r  <= 1'b0;
        ovf_r  <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        lcnt_r <= lcnt_nxt;
        lbeg_r <= lbeg_nxt;
        cand_r <= cand_nxt;
        uf_r   <= uf_nxt;
        hf_r   <= hf_nxt;
        fin_r  <= fin_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  // Line window and match positions are read only once written in the packet.
  always_ff @(posedge clk) begin
    if (adv) begin
      tail_r     <= tail_nxt;
      uri_off_r  <= uri_off_nxt;
      uri_len_r  <= uri_len_nxt;
      host_off_r <= host_off_nxt;
      host_len_r <= host_len_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_req_r      <= uf_nxt;
      out_uri_off_r  <= uf_nxt ? uri_off_nxt : 11'd0;
      out_uri_len_r  <= uf_nxt ? uri_len_nxt : 11'd0;
      out_host_r     <= hf_nxt;
      out_host_off_r <= hf_nxt ? host_off_nxt : 11'd0;
      out_host_len_r <= hf_nxt ? host_len_nxt : 11'd0;
      out_trunc_r    <= ovf_nxt;
    end
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.request_found = out_req_r;
  assign out_bus.uri_offset    = out_uri_off_r;
  assign out_bus.uri_length    = out_uri_len_r;
  assign out_bus.host_found    = out_host_r;
  assign out_bus.host_offset   = out_host_off_r;
  assign out_bus.host_length   = out_host_len_r;
  assign out_bus.truncated     = out_trunc_r;

endmodule

`default_nettype wire

// ----- hdl/hruhe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hruhe_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        request_found,
  input wire [10:0] uri_offset,
  input wire [10:0] uri_length,
  input wire        host_found,
  input wire [10:0] host_offset,
  input wire [10:0] host_length
);

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A missing request line reports zero position and length.
  a_uri_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !request_found |-> (uri_offset == 11'd0) && (uri_length == 11'd0))
    else $error("URI fields set without a request line");

  // A missing Host header reports zero position and length.
  a_host_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !host_found |-> (host_offset == 11'd0) && (host_length == 11'd0))
    else $error("host fields set without a Host header");

endmodule

bind http_request_uri_host_extract hruhe_checker u_hruhe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .request_found (out_bus.request_found),
  .uri_offset    (out_bus.uri_offset),
  .uri_length    (out_bus.uri_length),
  .host_found    (out_bus.host_found),
  .host_offset   (out_bus.host_offset),
  .host_length   (out_bus.host_length)
);

`default_nettype wire
